@@ sv/gbba_pkg.sv @@
// Shared types, codes and default sizes for the group block bitmap allocator.
package gbba_pkg;

  localparam int GROUPS_DEF           = 16;
  localparam int BLOCKS_PER_GROUP_DEF = 1024;
  localparam int WORD_BITS_DEF        = 32;
  localparam int RESERVED_BLOCKS      = 2;

  localparam int ACTION_W = 2;
  localparam int GROUP_W  = 8;
  localparam int BLOCK_W  = 14;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 10;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] GROUPS_IN_USE_RST = 5'd16;

  localparam int IN_W        = GROUP_W + BLOCK_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = STATUS_W + BLOCK_W + 1 + FREE_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_RD,
    S_MOD,
    S_SCAN,
    S_RESP
  } state_t;

endpackage

@@ sv/gbba_ram.sv @@
// Bitmap word memory with one write port and one registered read port.
module gbba_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/group_block_bitmap_allocator.sv @@
// Top level of the group block bitmap allocator with its sequencer and free counters.
// Free and query run decode, read, modify and respond; rejected ones skip to respond.
// Allocate runs decode, then a scan of the group's bitmap words (up to 32 at defaults),
// one word per cycle through a single read port and one find-first-free unit.
// One request is in work at a time; the next is accepted in the cycle after a result loads.
// After reset a clearing pass writes every bitmap word, 512 words at defaults.
module group_block_bitmap_allocator import gbba_pkg::*; #(
  parameter int GROUPS           = GROUPS_DEF,
  parameter int BLOCKS_PER_GROUP = BLOCKS_PER_GROUP_DEF,
  parameter int WORD_BITS        = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // group [7:0], block_number [21:8], zero [23:22]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // action [1:0]
  input  logic [ACTION_W-1:0]    s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status [1:0], allocated_block [15:2], is_used [16], free_count [26:17], zero [31:27]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int BPG      = BLOCKS_PER_GROUP;
  localparam int WB       = WORD_BITS;
  localparam int GW       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int LB       = $clog2(BPG);
  localparam int BW       = $clog2(WB);
  localparam int CW       = $clog2(BPG);
  localparam int WPG      = (BPG + WB - 1) / WB;
  localparam int WIW      = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int DEPTH    = GROUPS * WPG;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW       = $clog2(GROUPS * BPG);
  localparam int DW       = ((SW > BLOCK_W) ? SW : BLOCK_W) + 1;
  localparam int LASTBITS = BPG - (WPG - 1) * WB;
  localparam int SHIFT    = LB + BW;
  localparam int RECIP    = ((1 << SHIFT) + WB - 1) / WB;
  localparam int PW       = 2 * LB + 2;
  localparam int PAD_W    = OUT_TDATA_W - OUT_W;

  state_t state, state_next;

  logic [CFG_W-1:0]    giu;
  logic [ACTION_W-1:0] act_r;
  logic [GROUP_W-1:0]  grp_r;
  logic [BLOCK_W-1:0]  bn_r;
  logic                grp_ok_r;
  logic [LB-1:0]       li_r;
  logic [WIW-1:0]      widx_r;
  logic [BW-1:0]       bit_r;
  logic [WIW:0]        issue_idx;
  logic [WIW-1:0]      chk_idx;
  logic                chk_ok;
  logic [AW-1:0]       clr_addr;
  logic [STATUS_W-1:0] res_status;
  logic [BLOCK_W-1:0]  res_alloc;
  logic                res_used;
  logic [CW-1:0]       counters [GROUPS];

  logic [GW-1:0]  grp_idx;
  logic           grp_ok;
  logic [SW-1:0]  start_val;
  logic [DW-1:0]  bn_x;
  logic [DW-1:0]  st_x;
  logic [DW-1:0]  off;
  logic           blk_in_grp;
  logic [LB-1:0]  li;
  logic [PW-1:0]  prod;
  logic [WIW-1:0] quo;
  logic [BW-1:0]  rem;
  logic [AW-1:0]  base_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [WB-1:0]  mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [WB-1:0]  rdata;
  logic [WB-1:0]  avail;
  logic [BW:0]    ff;
  logic           ff_found;
  logic [BW-1:0]  ff_idx;
  logic [SW-1:0]  alloc_full;
  logic           rd_bit;
  logic [CW-1:0]  cnt_cur;
  logic           chk_last;
  logic           out_free;

  function automatic logic [BW:0] first_free(input logic [WB-1:0] v);
    logic [BW:0] r;
    r = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (v[j]) begin
        r = {1'b1, BW'(j)};
      end
    end
    return r;
  endfunction

  assign grp_idx   = grp_r[GW-1:0];
  assign grp_ok    = ({1'b0, grp_r} < (GROUP_W + 1)'(GROUPS)) && (grp_r < GROUP_W'(giu));
  assign start_val = SW'(int'(grp_idx) * BPG);
  assign bn_x      = DW'(bn_r);
  assign st_x      = DW'(start_val);
  assign off       = bn_x - st_x;
  assign blk_in_grp = (bn_x >= st_x) && (off < DW'(BPG)) && (off >= DW'(RESERVED_BLOCKS));
  assign li        = LB'(off);
  assign prod      = PW'(li) * PW'(RECIP);
  assign quo       = WIW'(prod >> SHIFT);
  assign rem       = BW'(li_r - LB'(int'(widx_r) * WB));
  assign base_addr = AW'(int'(grp_idx) * WPG);
  assign rd_bit    = rdata[bit_r];
  assign cnt_cur   = counters[grp_idx];
  assign chk_last  = (chk_idx == WIW'(WPG - 1));
  assign ff        = first_free(avail);
  assign ff_found  = ff[BW];
  assign ff_idx    = ff[BW-1:0];
  assign alloc_full = start_val + SW'(int'(chk_idx) * WB) + SW'(ff_idx);
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      avail[j] = !rdata[j] && !((chk_idx == '0) && (j < RESERVED_BLOCKS))
                 && !(chk_last && (j >= LASTBITS));
    end
  end

  always_comb begin
    if (state == S_SCAN) begin
      mem_raddr = base_addr + AW'(issue_idx);
    end else begin
      mem_raddr = base_addr + AW'(widx_r);
    end
  end

  gbba_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (WB)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = base_addr + AW'(widx_r);
    mem_wdata  = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        priority if (!grp_ok) begin
          state_next = S_RESP;
        end else if (act_r == ACT_ALLOC) begin
          state_next = S_SCAN;
        end else if (!blk_in_grp) begin
          state_next = S_RESP;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        if ((act_r == ACT_FREE) && rd_bit) begin
          mem_we    = 1'b1;
          mem_wdata = rdata & ~(WB'(1) << bit_r);
        end
        state_next = S_RESP;
      end
      S_SCAN: begin
        priority if (chk_ok && ff_found) begin
          mem_we     = 1'b1;
          mem_waddr  = base_addr + AW'(chk_idx);
          mem_wdata  = rdata | (WB'(1) << ff_idx);
          state_next = S_RESP;
        end else if (chk_ok && chk_last) begin
          state_next = S_RESP;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      giu      <= GROUPS_IN_USE_RST;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        counters[g] <= CW'(BPG - RESERVED_BLOCKS);
      end
    end else begin
      if (cfg_we) begin
        giu <= cfg_wdata;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if ((state == S_MOD) && (act_r == ACT_FREE) && rd_bit) begin
        counters[grp_idx] <= cnt_cur + CW'(1);
      end
      if ((state == S_SCAN) && chk_ok && ff_found && (cnt_cur != '0)) begin
        counters[grp_idx] <= cnt_cur - CW'(1);
      end
      if ((state == S_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && s_tvalid) begin
      act_r <= s_tuser;
      grp_r <= s_tdata[GROUP_W-1:0];
      bn_r  <= s_tdata[IN_W-1:GROUP_W];
    end
    if (state == S_DEC) begin
      grp_ok_r  <= grp_ok;
      li_r      <= li;
      widx_r    <= quo;
      issue_idx <= '0;
      chk_ok    <= 1'b0;
      res_alloc <= '0;
      priority if (!grp_ok) begin
        res_status <= ST_INVALID;
        res_used   <= (act_r != ACT_ALLOC) && (act_r != ACT_FREE);
      end else if (act_r == ACT_ALLOC) begin
        res_status <= ST_OK;
        res_used   <= 1'b0;
      end else if (!blk_in_grp) begin
        res_status <= ST_INVALID;
        res_used   <= (act_r != ACT_FREE);
      end else begin
        res_status <= ST_OK;
        res_used   <= 1'b0;
      end
    end
    if (state == S_RD) begin
      bit_r <= rem;
    end
    if ((state == S_MOD) && (act_r != ACT_FREE)) begin
      res_used <= rd_bit;
    end
    if (state == S_SCAN) begin
      issue_idx <= issue_idx + (WIW + 1)'(1);
      chk_idx   <= issue_idx[WIW-1:0];
      chk_ok    <= (issue_idx < (WIW + 1)'(WPG));
      if (chk_ok && ff_found) begin
        res_alloc <= BLOCK_W'(alloc_full);
      end else if (chk_ok && chk_last) begin
        res_status <= ST_NO_SPACE;
      end
    end
    if ((state == S_RESP) && out_free) begin
      m_tdata <= {{PAD_W{1'b0}}, (grp_ok_r ? FREE_W'(cnt_cur) : FREE_W'(0)),
                  res_used, res_alloc, res_status};
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DEC))
    else $error("accepted request did not enter decode");

  a_scan_write_checked: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_SCAN)) |-> (chk_ok && ff_found))
    else $error("bitmap written during scan without a free bit");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESP) && grp_ok_r) |-> (cnt_cur <= CW'(BPG - RESERVED_BLOCKS)))
    else $error("free counter above group capacity");

  a_no_space_alloc: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESP) && (res_status == ST_NO_SPACE)) |-> (act_r == ACT_ALLOC))
    else $error("no space reported for a request that is not an allocate");

  a_alloc_ok: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESP) && (res_alloc != '0)) |-> ((res_status == ST_OK) && (act_r == ACT_ALLOC)))
    else $error("block number reported without a successful allocate");

endmodule

@@ tb/tb.sv @@
// Self-checking stream testbench for the group block bitmap allocator.
module tb;
  import gbba_pkg::*;

  localparam int NUM_GROUPS = GROUPS_DEF;
  localparam int BLOCKS = BLOCKS_PER_GROUP_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT = 250;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BLOCK_W-1:0]  block;
    logic [GROUP_W-1:0]  group;
  } req_t;

  typedef struct packed {
    logic [FREE_W-1:0]   free_count;
    logic                used;
    logic [BLOCK_W-1:0]  alloc_block;
    logic [STATUS_W-1:0] status;
  } resp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [ACTION_W-1:0]    s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  req_t            pending_reqs [$];
  resp_t           expected_resps [$];
  req_t            on_bus;
  resp_t           got;
  resp_t           want;
  bit [BLOCKS-1:0] block_map [NUM_GROUPS];
  int              free_left [NUM_GROUPS];
  int              groups_live = GROUPS_IN_USE_RST;
  int              items_in = 0;
  int              hold_left = 0;
  bit              hold_done = 1'b0;
  int              cycles = 0;
  int              errors = 0;
  int              responses = 0;
  int              granted = 0;
  int              out_of_space = 0;
  int              rejected = 0;

  group_block_bitmap_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic resp_t predict_result(input req_t r);
    resp_t res;
    int    g;
    int    base;
    int    idx;
    bit    found;
    res = '0;
    g = r.group;
    if (g >= NUM_GROUPS || g >= groups_live) begin
      res.status = ST_INVALID;
      res.used = (r.action != ACT_ALLOC && r.action != ACT_FREE);
    end else begin
      base = g * BLOCKS;
      idx = int'(r.block) - base;
      if (r.action == ACT_ALLOC) begin
        found = 1'b0;
        for (int i = RESERVED_BLOCKS; i < BLOCKS && !found; i++) begin
          if (!block_map[g][i]) begin
            block_map[g][i] = 1'b1;
            if (free_left[g] > 0) free_left[g]--;
            res.alloc_block = BLOCK_W'(base + i);
            found = 1'b1;
          end
        end
        if (!found) res.status = ST_NO_SPACE;
      end else if (idx < RESERVED_BLOCKS || idx >= BLOCKS) begin
        res.status = ST_INVALID;
        res.used = (r.action != ACT_FREE);
      end else if (r.action == ACT_FREE) begin
        if (block_map[g][idx]) begin
          block_map[g][idx] = 1'b0;
          free_left[g]++;
        end
      end else begin
        res.used = block_map[g][idx];
      end
      res.free_count = FREE_W'(free_left[g]);
    end
    return res;
  endfunction

  function automatic int idle_pct(input bit sender);
    case ((items_in / 100) % 4)
      0: return 0;
      1: return sender ? 66 : 0;
      2: return sender ? 0 : 66;
      default: return 30;
    endcase
  endfunction

  function automatic req_t make_req(input logic [ACTION_W-1:0] action, input int group,
                                    input int block);
    req_t r;
    r.action = action;
    r.group = GROUP_W'(group);
    r.block = BLOCK_W'(block);
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   live;
    int   pick;
    int   base;
    live = (groups_live < NUM_GROUPS) ? groups_live : NUM_GROUPS;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.action = ACT_ALLOC;
    else if (pick < 70) r.action = ACT_FREE;
    else if (pick < 95) r.action = ACT_QUERY;
    else r.action = ACT_SPARE;
    if (live > 0 && $urandom_range(0, 99) < 88) r.group = GROUP_W'($urandom_range(0, live - 1));
    else r.group = GROUP_W'($urandom_range(0, 255));
    base = int'(r.group) * BLOCKS;
    pick = $urandom_range(0, 99);
    if (pick < 60) r.block = BLOCK_W'(base + $urandom_range(0, 95));
    else if (pick < 85) r.block = BLOCK_W'(base + $urandom_range(0, BLOCKS - 1));
    else r.block = BLOCK_W'($urandom_range(0, 16383));
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0) @(negedge clk);
  endtask

  task automatic set_groups(input int value);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    groups_live = value;
    @(negedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_reqs.push_back(random_req());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_resps.push_back(predict_result(on_bus));
        items_in <= items_in + 1;
      end
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        on_bus = pending_reqs.pop_front();
        s_tdata <= {{(IN_TDATA_W - IN_W){1'b0}}, on_bus.block, on_bus.group};
        s_tuser <= on_bus.action;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = resp_t'(m_tdata[OUT_W-1:0]);
        responses++;
        if (expected_resps.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) $display("tb: unexpected response %h", m_tdata);
        end else begin
          want = expected_resps.pop_front();
          if (got.status != want.status || got.alloc_block != want.alloc_block ||
              got.used != want.used || got.free_count != want.free_count) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("tb: response %0d expected status %0d block %0d used %0d free %0d, got status %0d block %0d used %0d free %0d",
                       responses, want.status, want.alloc_block, want.used, want.free_count,
                       got.status, got.alloc_block, got.used, got.free_count);
          end
          if (want.status == ST_NO_SPACE) out_of_space++;
          else if (want.status == ST_INVALID) rejected++;
          else if (want.alloc_block != '0) granted++;
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && items_in == HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int last_setting;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      block_map[g] = '0;
      free_left[g] = BLOCKS - RESERVED_BLOCKS;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_reqs.push_back(make_req(ACT_ALLOC, 0, 0));
    pending_reqs.push_back(make_req(ACT_ALLOC, 0, 16383));
    pending_reqs.push_back(make_req(ACT_ALLOC, 15, 0));
    pending_reqs.push_back(make_req(ACT_ALLOC, 16, 0));
    pending_reqs.push_back(make_req(ACT_ALLOC, 255, 16383));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 2));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 4));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 0));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 1));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 1024));
    pending_reqs.push_back(make_req(ACT_QUERY, 255, 16383));
    pending_reqs.push_back(make_req(ACT_FREE, 0, 2));
    pending_reqs.push_back(make_req(ACT_FREE, 0, 2));
    pending_reqs.push_back(make_req(ACT_FREE, 0, 1));
    pending_reqs.push_back(make_req(ACT_FREE, 1, 0));
    pending_reqs.push_back(make_req(ACT_FREE, 15, 16383));
    pending_reqs.push_back(make_req(ACT_QUERY, 15, 16383));
    pending_reqs.push_back(make_req(ACT_SPARE, 0, 3));
    pending_reqs.push_back(make_req(ACT_SPARE, 200, 5000));
    pending_reqs.push_back(make_req(ACT_ALLOC, 0, 7));
    pending_reqs.push_back(make_req(ACT_FREE, 16, 16384 - 1));
    pending_reqs.push_back(make_req(ACT_QUERY, 15, 15362));

    set_groups(0);
    queue_random(12);
    set_groups(31);
    queue_random(120);
    set_groups(1);
    repeat (BLOCKS) pending_reqs.push_back(make_req(ACT_ALLOC, 0, $urandom_range(0, 16383)));
    queue_random(40);
    set_groups(16);
    queue_random(100);
    last_setting = $urandom_range(2, 15);
    set_groups(last_setting);
    queue_random(60);

    wait_drained();
    repeat (40) @(posedge clk);
    $display("tb: %0d requests and %0d responses checked: %0d grants, %0d out of space, %0d rejected",
             items_in, responses, granted, out_of_space, rejected);
    $display("tb: group limits 16, 0, 31, 1, 16 and %0d, group 0 filled, one long output hold-off",
             last_setting);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/gbba_pkg.sv
sv/gbba_ram.sv
sv/group_block_bitmap_allocator.sv
tb/tb.sv
